// ===== hdl/whtm_pkg.sv =====
// Package for the window hit test block: FSM state and result status codes.
// Used by: window_hit_test_move_to_front. No dependencies.
`default_nettype none

package whtm_pkg;

	localparam int ID_W = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FRONT
	} state_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_HIT   = 2'd0,
		STAT_MISS  = 2'd1,
		STAT_ADDED = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/whtm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module whtm_ram #(
	parameter int WIDTH = 53,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/whtm_hit.sv =====
// Rectangle containment unit, inclusive bounds; shared by every search step.
// No dependencies.
`default_nettype none

module whtm_hit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic [COORD_BITS-1:0] x,
	input  wire logic [COORD_BITS-1:0] y,
	input  wire logic [COORD_BITS-1:0] left_x,
	input  wire logic [COORD_BITS-1:0] bottom_y,
	input  wire logic [COORD_BITS-1:0] right_x,
	input  wire logic [COORD_BITS-1:0] top_y,
	output logic                       hit
);

	always_comb begin
		hit = (x >= left_x) && (x <= right_x) && (y >= bottom_y) && (y <= top_y);
	end

endmodule

`default_nettype wire

// ===== hdl/window_hit_test_move_to_front.sv =====
// Top level of the window hit test with move-to-front stack.
// Depends on whtm_pkg, whtm_ram, whtm_hit.
//
// Usage: a transaction is taken when start is high and busy is low. command 0
// pushes the rectangle (left_x, bottom_y, right_x, top_y) on top of the stack
// with the next id; command 1 clicks at (left_x, bottom_y). Each transaction
// gives exactly one result, shown on status and window_id for one cycle with
// done high; the receiver cannot stall it.
// An add, a click on an empty stack and an add to a full stack
// report in the cycle after acceptance. A click walks the stack from the top
// through the single containment unit, one entry per cycle behind the
// registered RAM read. On a hit the entries above the hit one are each
// shifted down by one place, the hit entry is then written on top, and the
// result is reported; a miss reports once the bottom entry has been tested.
// The RAM has one write and one read port, which sets the one-entry-per-cycle
// pace.
// busy is high while a click walks the stack, until the result is shown; adds
// never raise it. start is ignored while busy; a new transaction can be taken
// in the cycle done is high. Reset empties the stack; RAM needs no clearing.
`default_nettype none

module window_hit_test_move_to_front #(
	parameter int MAX_WINDOWS = 16,
	parameter int COORD_BITS  = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  command,
	input  wire logic [COORD_BITS-1:0] left_x,
	input  wire logic [COORD_BITS-1:0] bottom_y,
	input  wire logic [COORD_BITS-1:0] right_x,
	input  wire logic [COORD_BITS-1:0] top_y,
	output logic                       done,
	output logic [whtm_pkg::STATUS_W-1:0] status,
	output logic [whtm_pkg::ID_W-1:0]  window_id
);

	localparam int ADDR_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
	localparam int ENT_W  = whtm_pkg::ID_W + 4 * COORD_BITS;

	whtm_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]      count_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [ADDR_W-1:0]     ptr_q, idx_q, wk_q;
	logic                  more_q, pend_q, wpend_q;
	logic [CNT_W-1:0]      rk_q;
	logic [ENT_W-1:0]      sel_q;
	logic                  done_q;
	logic [whtm_pkg::STATUS_W-1:0] status_q;
	logic [whtm_pkg::ID_W-1:0]     window_id_q;

	logic                  accept, is_full, add_ok;
	logic                  srch_hit, srch_miss, shift_end, hit_w;
	logic [whtm_pkg::ID_W-1:0] id_new;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
	logic [ENT_W-1:0]      ram_wdata, ram_rdata;

	assign busy      = (state_q != whtm_pkg::ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign window_id = window_id_q;

	assign accept  = start && !busy;
	assign is_full = (count_q == CNT_W'(MAX_WINDOWS));
	assign add_ok  = accept && !command && !is_full;
	assign id_new  = whtm_pkg::ID_W'(32'(count_q) + 32'd1);

	whtm_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_WINDOWS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	whtm_hit #(
		.COORD_BITS(COORD_BITS)
	) u_hit (
		.x       (x_q),
		.y       (y_q),
		.left_x  (ram_rdata[4*COORD_BITS-1:3*COORD_BITS]),
		.bottom_y(ram_rdata[3*COORD_BITS-1:2*COORD_BITS]),
		.right_x (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
		.top_y   (ram_rdata[COORD_BITS-1:0]),
		.hit     (hit_w)
	);

	assign srch_hit  = (state_q == whtm_pkg::ST_SEARCH) && pend_q && hit_w;
	assign srch_miss = (state_q == whtm_pkg::ST_SEARCH) && pend_q && !hit_w &&
		(idx_q == '0);
	assign shift_end = (state_q == whtm_pkg::ST_SHIFT) && (rk_q == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			whtm_pkg::ST_IDLE: begin
				if (accept && command && (count_q != '0)) begin
					state_d = whtm_pkg::ST_SEARCH;
				end
			end
			whtm_pkg::ST_SEARCH: begin
				if (srch_hit) begin
					state_d = whtm_pkg::ST_SHIFT;
				end else if (srch_miss) begin
					state_d = whtm_pkg::ST_IDLE;
				end
			end
			whtm_pkg::ST_SHIFT: begin
				if (shift_end) begin
					state_d = whtm_pkg::ST_FRONT;
				end
			end
			whtm_pkg::ST_FRONT: begin
				state_d = whtm_pkg::ST_IDLE;
			end
			default: begin
				state_d = whtm_pkg::ST_IDLE;
			end
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = {id_new, left_x, bottom_y, right_x, top_y};
		ram_raddr = ptr_q;
		case (state_q)
			whtm_pkg::ST_IDLE: begin
				ram_we = add_ok;
			end
			whtm_pkg::ST_SEARCH: begin
				ram_raddr = ptr_q;
			end
			whtm_pkg::ST_SHIFT: begin
				ram_raddr = rk_q[ADDR_W-1:0];
				ram_we    = wpend_q;
				ram_waddr = wk_q;
				ram_wdata = ram_rdata;
			end
			whtm_pkg::ST_FRONT: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(count_q - CNT_W'(1));
				ram_wdata = sel_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whtm_pkg::ST_IDLE;
			count_q <= '0;
			more_q  <= 1'b0;
			pend_q  <= 1'b0;
			wpend_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				whtm_pkg::ST_IDLE: begin
					if (accept) begin
						if (!command) begin
							done_q <= 1'b1;
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							more_q <= 1'b1;
							pend_q <= 1'b0;
						end
					end
				end
				whtm_pkg::ST_SEARCH: begin
					if (srch_hit) begin
						wpend_q <= 1'b0;
					end else if (srch_miss) begin
						done_q <= 1'b1;
						pend_q <= 1'b0;
					end else if (more_q) begin
						pend_q <= 1'b1;
						if (ptr_q == '0) begin
							more_q <= 1'b0;
						end
					end else begin
						pend_q <= 1'b0;
					end
				end
				whtm_pkg::ST_SHIFT: begin
					wpend_q <= !shift_end;
				end
				whtm_pkg::ST_FRONT: begin
					done_q <= 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			whtm_pkg::ST_IDLE: begin
				if (accept) begin
					x_q   <= left_x;
					y_q   <= bottom_y;
					ptr_q <= ADDR_W'(count_q - CNT_W'(1));
					if (!command) begin
						status_q    <= is_full ? whtm_pkg::STAT_FULL : whtm_pkg::STAT_ADDED;
						window_id_q <= is_full ? '0 : id_new;
					end else begin
						status_q    <= whtm_pkg::STAT_MISS;
						window_id_q <= '0;
					end
				end
			end
			whtm_pkg::ST_SEARCH: begin
				if (srch_hit) begin
					sel_q <= ram_rdata;
					rk_q  <= CNT_W'(idx_q) + CNT_W'(1);
				end else if (srch_miss) begin
					status_q    <= whtm_pkg::STAT_MISS;
					window_id_q <= '0;
				end else if (more_q) begin
					idx_q <= ptr_q;
					if (ptr_q != '0) begin
						ptr_q <= ptr_q - ADDR_W'(1);
					end
				end
			end
			whtm_pkg::ST_SHIFT: begin
				if (!shift_end) begin
					wk_q <= ADDR_W'(rk_q - CNT_W'(1));
					rk_q <= rk_q + CNT_W'(1);
				end
			end
			whtm_pkg::ST_FRONT: begin
				status_q    <= whtm_pkg::STAT_HIT;
				window_id_q <= sel_q[ENT_W-1:4*COORD_BITS];
			end
			default: begin
				sel_q <= sel_q;
			end
		endcase
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WINDOWS))
		else $error("window count above table size");

	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted transaction neither answered nor in progress");

	a_added_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == whtm_pkg::STAT_ADDED)) |->
		(window_id == whtm_pkg::ID_W'(32'(count_q))))
		else $error("added id does not match window count");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((status == whtm_pkg::STAT_MISS) || (status == whtm_pkg::STAT_FULL)))
		|-> (window_id == '0))
		else $error("nonzero id on miss or full");

endmodule

`default_nettype wire
